// ===== design/slcd_pkg.sv =====
// Package for the sync/length/checksum deframer: phase and kind codes,
// and the result struct passed from parser to output register. No dependencies.
package slcd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAB;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5F;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_SEQ   = 3'd2,
        PH_LEN   = 3'd3,
        PH_CMD   = 3'd4,
        PH_PAY   = 3'd5,
        PH_CSUM  = 3'd6
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEQ  = 3'd0,
        KIND_LEN  = 3'd1,
        KIND_CMD  = 3'd2,
        KIND_PAY  = 3'd3,
        KIND_CSUM = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 1'b0,
        CFG_SYNC_SECOND = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        t_kind             byte_kind;
        logic              end_of_frame;
        logic              checksum_good;
    } t_result;

endpackage

// ===== design/slcd_in_if.sv =====
// Input channel of the deframer: one received byte per item.
// Depends on slcd_pkg.
interface slcd_in_if import slcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/slcd_out_if.sv =====
// Output channel of the deframer: one tagged frame byte per item.
// Depends on slcd_pkg.
interface slcd_out_if import slcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic [KIND_W-1:0] byte_kind;
    logic              end_of_frame;
    logic              checksum_good;

    modport source (output valid, output frame_byte, output byte_kind,
                    output end_of_frame, output checksum_good, input ready);
    modport sink   (input valid, input frame_byte, input byte_kind,
                    input end_of_frame, input checksum_good, output ready);
endinterface

// ===== design/sync_length_checksum_deframer_top.sv =====
// Top level of the sync/length/checksum deframer: parser plus output register.
// Depends on slcd_pkg, slcd_in_if, slcd_out_if, slcd_parser, slcd_out_reg.
//
// Takes one received byte per item on i_rx and hunts for the two-byte sync
// word (registers sync_first, index 0, reset 0xAB; sync_second, index 1,
// reset 0x5F). After sync it emits, one item each, the sequence, length,
// command, length payload bytes and the checksum byte on o_frame, each tagged
// with byte_kind. The checksum item carries end_of_frame and checksum_good
// (checksum equals the 8-bit sum of length, command and payload). Sync bytes
// give no item; a bad second sync byte drops back to the hunt. Rate: one item
// per cycle sustained while o_frame.ready is high; a byte is parsed
// combinationally in the cycle it is accepted and its result lands in the output
// register, visible in the next cycle. i_rx.ready is low only while the output
// register is full and o_frame.ready is low. Write configuration only while idle.
module sync_length_checksum_deframer_top import slcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    slcd_in_if.sink              i_rx,
    slcd_out_if.source           o_frame
);

    logic    w_ready;
    logic    w_step;
    logic    w_res_valid;
    t_result w_res;

    assign i_rx.ready = w_ready;
    assign w_step     = i_rx.valid && w_ready;

    slcd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_step      (w_step),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result valid already includes the step qualifier
    slcd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_ready (w_ready),
        .o_frame (o_frame)
    );

endmodule

// ===== design/slcd_parser.sv =====
// Frame parser: sync registers, phase FSM, length count and running sum.
// Depends on slcd_pkg.
module slcd_parser import slcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_step,
    input  logic [BYTE_W-1:0]    i_byte,
    output logic                 o_res_valid,
    output t_result              o_res
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_left,  n_left;
    logic [BYTE_W-1:0] r_sum,   n_sum;
    logic [BYTE_W-1:0] r_sync_first, r_sync_second;
    logic [BYTE_W-1:0] w_sum_add;
    logic [BYTE_W-1:0] w_left_dec;

    assign w_sum_add  = r_sum + i_byte;
    assign w_left_dec = (r_left != '0) ? r_left - 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_sum   = r_sum;
        case (r_phase)
            PH_HUNT2: n_phase = (i_byte == r_sync_second) ? PH_SEQ : PH_HUNT1;
            PH_SEQ:   n_phase = PH_LEN;
            PH_LEN: begin
                n_left  = i_byte;
                n_sum   = i_byte;
                n_phase = PH_CMD;
            end
            PH_CMD: begin
                n_sum   = w_sum_add;
                n_phase = (r_left != '0) ? PH_PAY : PH_CSUM;
            end
            PH_PAY: begin
                n_sum  = w_sum_add;
                n_left = w_left_dec;
                if (w_left_dec == '0) begin
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                n_phase = PH_HUNT1;
                n_left  = '0;
                n_sum   = '0;
            end
            default: n_phase = (i_byte == r_sync_first) ? PH_HUNT2 : PH_HUNT1;
        endcase
    end

    // outputs
    always_comb begin
        o_res_valid         = i_step;
        o_res.frame_byte    = i_byte;
        o_res.byte_kind     = KIND_SEQ;
        o_res.end_of_frame  = 1'b0;
        o_res.checksum_good = 1'b0;
        case (r_phase)
            PH_SEQ: o_res.byte_kind = KIND_SEQ;
            PH_LEN: o_res.byte_kind = KIND_LEN;
            PH_CMD: o_res.byte_kind = KIND_CMD;
            PH_PAY: o_res.byte_kind = KIND_PAY;
            PH_CSUM: begin
                o_res.byte_kind     = KIND_CSUM;
                o_res.end_of_frame  = 1'b1;
                o_res.checksum_good = (i_byte == r_sum);
            end
            default: o_res_valid = 1'b0;   // sync hunt: no item out
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_left  <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_sum   <= n_sum;
        end
    end

`ifndef SYNTHESIS
    a_csum_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_CSUM) |=> (r_phase == PH_HUNT1 && r_sum == '0))
        else $error("parser did not return to hunt after checksum");
    a_pay_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_left != '0))
        else $error("payload phase with zero bytes left");
`endif

endmodule

// ===== design/slcd_out_reg.sv =====
// Output register: holds one result item while the sink stalls and
// accepts a new one whenever it is empty or being drained. Depends on slcd_pkg.
module slcd_out_reg import slcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_res,
    output logic       o_ready,
    slcd_out_if.source o_frame
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_ready = !r_valid || o_frame.ready;
    assign n_valid = i_load || (r_valid && !o_frame.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_frame.valid         = r_valid;
    assign o_frame.frame_byte    = r_res.frame_byte;
    assign o_frame.byte_kind     = r_res.byte_kind;
    assign o_frame.end_of_frame  = r_res.end_of_frame;
    assign o_frame.checksum_good = r_res.checksum_good;

`ifndef SYNTHESIS
    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("result loaded into a full, stalled register");
    a_eof_is_csum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.end_of_frame == (r_res.byte_kind == KIND_CSUM)))
        else $error("end_of_frame out of step with checksum kind");
`endif

endmodule

// ===== sim/tb_sync_length_checksum_deframer_top.sv =====
// Self-checking testbench for sync_length_checksum_deframer_top.
// Depends on slcd_pkg, slcd_in_if, slcd_out_if and the deframer RTL; the
// expected item stream comes from a behavioral parser kept in this file.
module tb_sync_length_checksum_deframer_top;
    import slcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling for ~2.5k bytes even with 68% idling on either side;
    // reaching it means the block hung.
    localparam int unsigned CYCLE_LIMIT = 500000;
    // Keep the log readable when the block is badly broken.
    localparam int unsigned MAX_REPORTS = 50;
    localparam int unsigned ITEMS_PER_RANDOM_TEST = 560;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;

    slcd_in_if  rx_if ();
    slcd_out_if frame_if ();

    sync_length_checksum_deframer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_frame    (frame_if)
    );

    // ------------------------------------------------------------------
    // Clock, cycle counter and hang guard
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Behavioral deframer: shadow of the sync registers and parse state.
    // Updated once per accepted byte, in acceptance order.
    // ------------------------------------------------------------------
    logic [7:0] sync_first_val;
    logic [7:0] sync_second_val;
    t_phase     parse_phase;
    logic [8:0] pay_left;
    logic [7:0] sum_acc;

    t_result    frame_expect_q[$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent = 0;

    // Percent of cycles each side holds off; set per test
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Returns 1 when the byte produces an output item, filled into res.
    function automatic bit predict_frame_byte(input logic [7:0] rx_b, output t_result res);
        bit emits;
        emits = 1'b1;
        res = '0;
        res.frame_byte = rx_b;
        case (parse_phase)
            PH_HUNT2: begin
                emits = 1'b0;
                // A bad second byte is dropped, never re-tested as a first byte
                if (rx_b == sync_second_val) parse_phase = PH_SEQ;
                else parse_phase = PH_HUNT1;
            end
            PH_SEQ: begin
                res.byte_kind = KIND_SEQ;
                parse_phase = PH_LEN;
            end
            PH_LEN: begin
                res.byte_kind = KIND_LEN;
                pay_left = {1'b0, rx_b};
                sum_acc = rx_b;
                parse_phase = PH_CMD;
            end
            PH_CMD: begin
                res.byte_kind = KIND_CMD;
                sum_acc = sum_acc + rx_b;
                // zero length goes straight to the checksum
                if (pay_left != 9'd0) parse_phase = PH_PAY;
                else parse_phase = PH_CSUM;
            end
            PH_PAY: begin
                res.byte_kind = KIND_PAY;
                sum_acc = sum_acc + rx_b;
                if (pay_left != 9'd0) pay_left = pay_left - 9'd1;
                if (pay_left == 9'd0) parse_phase = PH_CSUM;
            end
            PH_CSUM: begin
                res.byte_kind = KIND_CSUM;
                res.end_of_frame = 1'b1;
                res.checksum_good = (rx_b == sum_acc);
                parse_phase = PH_HUNT1;
                pay_left = 9'd0;
                sum_acc = 8'd0;
            end
            default: begin
                // hunting first sync byte (unused codes land here too)
                emits = 1'b0;
                if (rx_b == sync_first_val) parse_phase = PH_HUNT2;
                else parse_phase = PH_HUNT1;
            end
        endcase
        return emits;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure plus in-order checking.
    // Values seen right after the edge are the pre-edge ones, so the
    // handshake test matches what the block saw.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : frame_checker
        t_result want;
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            if (frame_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item byte=%h kind=%0d",
                                          frame_if.frame_byte, frame_if.byte_kind));
            end else begin
                want = frame_expect_q.pop_front();
                if (frame_if.frame_byte !== want.frame_byte)
                    report_mismatch($sformatf("frame_byte %h, want %h",
                                              frame_if.frame_byte, want.frame_byte));
                if (frame_if.byte_kind !== want.byte_kind)
                    report_mismatch($sformatf("byte_kind %0d, want %0d (byte %h)",
                                              frame_if.byte_kind, want.byte_kind,
                                              want.frame_byte));
                if (frame_if.end_of_frame !== want.end_of_frame)
                    report_mismatch($sformatf("end_of_frame %b, want %b (byte %h)",
                                              frame_if.end_of_frame, want.end_of_frame,
                                              want.frame_byte));
                if (frame_if.checksum_good !== want.checksum_good)
                    report_mismatch($sformatf("checksum_good %b, want %b (byte %h)",
                                              frame_if.checksum_good, want.checksum_good,
                                              want.frame_byte));
            end
        end
        frame_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte, with random idle cycles ahead of it, and hold it until
    // accepted. valid stays high on return; the next call or an idle drop
    // decides its value in the following step.
    task automatic send_byte(input logic [7:0] b);
        t_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        bytes_sent++;
        if (predict_frame_byte(b, res)) frame_expect_q.push_back(res);
    endtask

    // One complete frame behind the current sync word. fill < 0 gives a
    // random payload, otherwise every payload byte is fill.
    task automatic send_frame(input logic [7:0] seq_byte, input logic [7:0] len,
                              input logic [7:0] cmd, input int fill, input bit good);
        logic [7:0] frame_sum;
        logic [7:0] pay;
        send_byte(sync_first_val);
        send_byte(sync_second_val);
        send_byte(seq_byte);
        send_byte(len);
        send_byte(cmd);
        frame_sum = len + cmd;
        for (int i = 0; i < len; i++) begin
            pay = (fill < 0) ? 8'($urandom) : fill[7:0];
            frame_sum = frame_sum + pay;
            send_byte(pay);
        end
        if (good) send_byte(frame_sum);
        else send_byte(frame_sum ^ 8'($urandom_range(1, 255)));
    endtask

    // Sync word start followed by a wrong second byte.
    task automatic send_broken_sync();
        logic [7:0] bad;
        bad = 8'($urandom);
        if (bad == sync_second_val) bad = bad ^ 8'h01;
        send_byte(sync_first_val);
        send_byte(bad);
    endtask

    // Feed filler until the parser is back to hunting the first sync byte.
    task automatic return_to_hunt();
        while (parse_phase != PH_HUNT1) begin
            if (parse_phase == PH_HUNT2) send_byte(~sync_second_val);
            else send_byte(8'($urandom));
        end
    endtask

    // Register writes only with nothing in flight. The extra cycles cover a
    // last byte that produced no item but is still in the parser.
    task automatic write_sync_reg(input t_cfg_idx idx, input logic [7:0] value);
        rx_if.valid <= 1'b0;
        while (frame_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SYNC_FIRST) sync_first_val = value;
        else sync_second_val = value;
    endtask

    task automatic set_idle_mode(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset sync word; hunt behavior and frame edge cases.
    task automatic test_directed_cases();
        // non-matching first byte is consumed alone
        send_byte(8'h00);
        // first byte twice: the second is a bad second byte and is not
        // re-tested, so the following 0x5F is just noise
        send_byte(sync_first_val);
        send_byte(sync_first_val);
        send_byte(sync_second_val);
        // zero length, zero sequence, command 0xFF, checksum 0xFF good
        send_frame(8'h00, 8'h00, 8'hFF, 0, 1'b1);
        // payload of 0xFF with 8-bit wrap in the sum, good checksum
        send_frame(8'hFF, 8'h02, 8'h00, 255, 1'b1);
        // one payload byte, wrong checksum
        send_frame(8'h12, 8'h01, 8'h34, 0, 1'b0);
    endtask

    // Both registers at their extremes, equal sync bytes, longest frame.
    task automatic test_sync_registers();
        return_to_hunt();
        write_sync_reg(CFG_SYNC_FIRST, 8'h00);
        write_sync_reg(CFG_SYNC_SECOND, 8'hFF);
        send_byte(8'hFF);
        send_frame(8'hA5, 8'h03, 8'h5A, -1, 1'b1);
        send_broken_sync();
        send_frame(8'h5A, 8'h00, 8'h00, -1, 1'b0);

        write_sync_reg(CFG_SYNC_FIRST, 8'hFF);
        write_sync_reg(CFG_SYNC_SECOND, 8'h00);
        send_frame(8'h7E, 8'hFF, 8'h81, -1, 1'b1);
        send_frame(8'h01, 8'h01, 8'hFE, 0, 1'b0);

        // identical sync bytes: the pair lines up on the first two
        write_sync_reg(CFG_SYNC_FIRST, 8'h5A);
        write_sync_reg(CFG_SYNC_SECOND, 8'h5A);
        send_frame(8'h5A, 8'h02, 8'h5A, 90, 1'b1);
    endtask

    // Mostly well-formed frames with random content, mixed with noise and
    // broken sync words, under a fresh random sync word.
    task automatic test_random_stream(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        logic [7:0]  len;
        return_to_hunt();
        write_sync_reg(CFG_SYNC_FIRST, 8'($urandom));
        write_sync_reg(CFG_SYNC_SECOND, 8'($urandom));
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if (parse_phase != PH_HUNT1) return_to_hunt();
                pick = $urandom_range(0, 99);
                if (pick < 2) len = 8'hFF;
                else if (pick < 6) len = 8'($urandom_range(13, 254));
                else len = 8'($urandom_range(0, 12));
                send_frame(8'($urandom), len, 8'($urandom), -1,
                           $urandom_range(0, 99) < 75);
            end else if (pick < 85) begin
                send_byte(8'($urandom));
            end else begin
                send_broken_sync();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_SYNC_FIRST;
        i_cfg_data      <= '0;
        rx_if.valid     <= 1'b0;
        rx_if.rx_byte   <= '0;

        sync_first_val  = SYNC_FIRST_RST;
        sync_second_val = SYNC_SECOND_RST;
        parse_phase     = PH_HUNT1;
        pay_left        = 9'd0;
        sum_acc         = 8'd0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle_mode(29, 68);
        test_directed_cases();
        test_sync_registers();
        test_random_stream(ITEMS_PER_RANDOM_TEST);

        set_idle_mode(68, 29);
        test_random_stream(ITEMS_PER_RANDOM_TEST);

        set_idle_mode(0, 0);
        test_random_stream(ITEMS_PER_RANDOM_TEST);

        // drain; the cycle limit bounds this wait
        rx_if.valid <= 1'b0;
        while (frame_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && frame_expect_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
